>>> src/bfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bfa_pkg;

   typedef enum logic [2:0] {
      CMD_ALLOC,
      CMD_FREE,
      CMD_ALLOC_RUN,
      CMD_FREE_RUN,
      CMD_ADDREF,
      CMD_QUERY,
      CMD_RESERVE,
      CMD_RELEASE
   } bfa_cmd_type;

   typedef enum logic [1:0] {
      STS_OK,
      STS_NO_FRAME,
      STS_ZERO_LEN,
      STS_SATURATED
   } bfa_status_type;

   // datapath operations, one per cycle
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_CLEAR,
      OP_WRAP,
      OP_NEXT,
      OP_TAKE1,
      OP_FAIL,
      OP_EXEC,
      OP_ZLEN,
      OP_BLOCK,
      OP_STEP,
      OP_REBASE,
      OP_MARK_START,
      OP_MARK,
      OP_RUN_DONE,
      OP_RFREE
   } bfa_op_type;

   typedef struct packed {
      bfa_op_type op;
      logic       push;
   } bfa_ctl_type;

   typedef struct packed {
      logic empty;        // scan position reached its limit
      logic hit_free;     // free frame in the masked row
      logic hit_used;     // used frame in the masked row
      logic len_zero;
      logic over;         // run end beyond managed frames
      logic base_le_blk;  // run base not yet past the blocking frame
      logic clr_last;
   } bfa_sts_type;

   localparam int ROW_BITS    = 64;
   localparam int ROW_SHIFT   = 6;
   localparam int REF_PER_ROW = 8;
   localparam int REF_SHIFT   = 3;
   localparam int REF_W       = 8;

endpackage

`default_nettype wire

>>> src/bfa_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bfa_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   logic [15:0] frame_index;
   logic [16:0] run_length;
   logic [16:0] run_align;

   modport source (output valid, cmd, frame_index, run_length, run_align, input ready);
   modport sink (input valid, cmd, frame_index, run_length, run_align, output ready);
endinterface

interface bfa_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] result_frame;
   logic [7:0]  ref_count;
   logic [16:0] used_total;

   modport source (output valid, status, result_frame, ref_count, used_total, input ready);
   modport sink (input valid, status, result_frame, ref_count, used_total, output ready);
endinterface

`default_nettype wire

>>> src/bitmap_frame_allocator_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake      Payload
// req_ch    in   valid/ready    cmd, frame_index, run_length, run_align
// rsp_ch    out  valid/ready    status, result_frame, ref_count, used_total
// csr       in   csr_wr_en      csr_wr_data (frame_total)
//
// One item at a time. Every bitmap row visited takes the registered read of the
// 64-bit bitmap memory, then the check. Alloc scans from the hint up to the frame
// total and, when that finds no free frame, wraps and scans from frame zero up to
// the hint; free run visits each row of the run; single-frame commands do one read
// and then execute. Alloc run steps the aligned base past each blocking frame and
// then marks the rows of the run.
// After reset a clearing pass writes MAX_FRAMES / 8 rows, one per cycle, before
// the first item is taken. A stalled result holds in the output register; the
// next item is taken meanwhile and waits at its end for the register to empty.

module bitmap_frame_allocator_top #(
   parameter int MAX_FRAMES = 65536
) (
   input  logic         clock,
   input  logic         reset,
   bfa_req_if.sink      req_ch,
   bfa_rsp_if.source    rsp_ch,
   input  logic         csr_wr_en,
   input  logic [16:0]  csr_wr_data
);
   import bfa_pkg::*;

   bfa_ctl_type ctl;
   bfa_sts_type sts;

   // sequencing: accepts items, steps the scan, owns the result handshake
   bfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .req_cmd   (req_ch.cmd),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .ctl       (ctl),
      .sts       (sts)
   );

   // bitmap and refcount memories, scan registers, counters, result register
   bfa_datapath #(
      .MAX_FRAMES (MAX_FRAMES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_cmd          (req_ch.cmd),
      .req_frame_index  (req_ch.frame_index),
      .req_run_length   (req_ch.run_length),
      .req_run_align    (req_ch.run_align),
      .ctl              (ctl),
      .sts              (sts),
      .rsp_status       (rsp_ch.status),
      .rsp_result_frame (rsp_ch.result_frame),
      .rsp_ref_count    (rsp_ch.ref_count),
      .rsp_used_total   (rsp_ch.used_total)
   );

endmodule

`default_nettype wire

>>> src/bfa_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module bfa_datapath #(
   parameter int MAX_FRAMES = 65536
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [16:0]          csr_wr_data,
   input  logic [2:0]           req_cmd,
   input  logic [15:0]          req_frame_index,
   input  logic [16:0]          req_run_length,
   input  logic [16:0]          req_run_align,
   input  bfa_pkg::bfa_ctl_type ctl,
   output bfa_pkg::bfa_sts_type sts,
   output logic [1:0]           rsp_status,
   output logic [15:0]          rsp_result_frame,
   output logic [7:0]           rsp_ref_count,
   output logic [16:0]          rsp_used_total
);
   import bfa_pkg::*;

   localparam int FCW   = $clog2(MAX_FRAMES + 1);
   localparam int UW    = (FCW > 17) ? FCW : 17;
   localparam int CW    = UW + 2;
   localparam int ROWS  = (MAX_FRAMES + ROW_BITS - 1) / ROW_BITS;
   localparam int RAW   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int RROWS = (MAX_FRAMES + REF_PER_ROW - 1) / REF_PER_ROW;
   localparam int RRAW  = $clog2(RROWS);

   logic [ROW_BITS-1:0] map_mem [ROWS];
   logic [ROW_BITS-1:0] ref_mem [RROWS];

   logic [16:0]         total_ff;
   logic [CW-1:0]       hint_ff;
   logic [UW-1:0]       used_ff;
   logic [RRAW-1:0]     clr_ff;

   bfa_cmd_type         cmd_ff;
   logic [15:0]         idx_ff;
   logic [16:0]         len_ff;
   logic [CW-1:0]       aln_ff, pos_ff, lim_ff, base_ff, blk_ff;
   bfa_status_type      status_ff;
   logic [15:0]         frame_ff;
   logic [7:0]          refs_ff;
   logic [ROW_BITS-1:0] row_ff, rrow_ff;

   logic [CW-1:0]       max_c, tot, ixw, rbase, row_end, lim_off, aln_eff, ridx, rlim;
   logic                full, in_refs, in_tot, cur_bit;
   logic [ROW_BITS-1:0] mask, free_m, used_m, bit_m;
   logic [ROW_SHIFT-1:0] first_free, first_used;
   logic [ROW_SHIFT:0]  pcnt;
   logic [REF_W-1:0]    ref_val;
   logic [RAW-1:0]      map_rd_addr, map_wa;
   logic [RRAW-1:0]     ref_addr, ref_wa;
   logic                map_we, ref_we;
   logic [ROW_BITS-1:0] map_wd, ref_wd;

   always_comb begin
      max_c   = CW'(MAX_FRAMES);
      tot     = (CW'(total_ff) < max_c) ? CW'(total_ff) : max_c;
      ixw     = CW'(idx_ff);
      rbase   = pos_ff & ~CW'(ROW_BITS - 1);
      row_end = rbase + CW'(ROW_BITS);
      full    = lim_ff >= row_end;
      lim_off = lim_ff - rbase;
      in_refs = ixw < max_c;
      in_tot  = ixw < tot;
      cur_bit = row_ff[idx_ff[ROW_SHIFT-1:0]];
      bit_m   = ROW_BITS'(1) << idx_ff[ROW_SHIFT-1:0];
      ref_val = rrow_ff[{idx_ff[REF_SHIFT-1:0], 3'b000} +: REF_W];
      aln_eff = (req_run_align == 17'd0) ? CW'(1) : CW'(req_run_align);
      ridx    = CW'(req_frame_index);
      rlim    = ridx + CW'(req_run_length);
      map_rd_addr = pos_ff[ROW_SHIFT +: RAW];
      ref_addr    = ixw[REF_SHIFT +: RRAW];
   end

   // bits of the current row that lie in [pos, lim)
   always_comb begin
      for (int i = 0; i < ROW_BITS; i++) begin
         mask[i] = ((ROW_SHIFT+1)'(i) >= {1'b0, pos_ff[ROW_SHIFT-1:0]}) &&
                   (full || ((ROW_SHIFT+1)'(i) < lim_off[ROW_SHIFT:0]));
      end
      free_m = ~row_ff & mask;
      used_m = row_ff & mask;
   end

   always_comb begin
      first_free = '0;
      first_used = '0;
      pcnt       = '0;
      for (int i = ROW_BITS - 1; i >= 0; i--) begin
         if (free_m[i]) first_free = ROW_SHIFT'(i);
         if (used_m[i]) first_used = ROW_SHIFT'(i);
      end
      for (int i = 0; i < ROW_BITS; i++) begin
         pcnt = pcnt + (ROW_SHIFT+1)'(used_m[i]);
      end
   end

   always_comb begin
      sts.empty       = pos_ff >= lim_ff;
      sts.hit_free    = |free_m;
      sts.hit_used    = |used_m;
      sts.len_zero    = len_ff == 17'd0;
      sts.over        = lim_ff > tot;
      sts.base_le_blk = base_ff <= blk_ff;
      sts.clr_last    = clr_ff == RRAW'(RROWS - 1);
   end

   // memory write port selection
   always_comb begin
      logic [ROW_BITS-1:0] nrow;
      nrow   = rrow_ff;
      map_we = 1'b0;
      ref_we = 1'b0;
      map_wa = map_rd_addr;
      ref_wa = ref_addr;
      map_wd = row_ff;
      unique case (ctl.op)
         OP_CLEAR: begin
            map_we = 32'(clr_ff) < ROWS;
            map_wa = clr_ff[RAW-1:0];
            map_wd = '0;
            ref_we = 1'b1;
            ref_wa = clr_ff;
            nrow   = '0;
         end
         OP_TAKE1: begin
            map_we = 1'b1;
            map_wd = row_ff | (ROW_BITS'(1) << first_free);
         end
         OP_MARK: begin
            map_we = 1'b1;
            map_wd = row_ff | mask;
         end
         OP_RFREE: begin
            map_we = 1'b1;
            map_wd = row_ff & ~mask;
         end
         OP_EXEC: begin
            unique case (cmd_ff)
               CMD_FREE: begin
                  if (in_refs && ref_val != '0) begin
                     ref_we = 1'b1;
                     nrow[{idx_ff[REF_SHIFT-1:0], 3'b000} +: REF_W] = ref_val - 8'd1;
                  end else begin
                     map_we = in_tot && cur_bit;
                     map_wd = row_ff & ~bit_m;
                  end
               end
               CMD_ADDREF: begin
                  ref_we = in_refs && (ref_val != 8'hFF);
                  nrow[{idx_ff[REF_SHIFT-1:0], 3'b000} +: REF_W] = ref_val + 8'd1;
               end
               CMD_RESERVE: begin
                  map_we = in_tot && !cur_bit;
                  map_wd = row_ff | bit_m;
               end
               CMD_RELEASE: begin
                  map_we = in_tot && cur_bit;
                  map_wd = row_ff & ~bit_m;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      ref_wd = nrow;
   end

   always_ff @(posedge clock) begin
      if (map_we) map_mem[map_wa] <= map_wd;
      if (ref_we) ref_mem[ref_wa] <= ref_wd;
      row_ff  <= map_mem[map_rd_addr];
      rrow_ff <= ref_mem[ref_addr];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         hint_ff  <= '0;
         used_ff  <= '0;
         clr_ff   <= '0;
      end else begin
         if (csr_wr_en) total_ff <= csr_wr_data;
         unique case (ctl.op)
            OP_CLEAR: clr_ff <= clr_ff + RRAW'(1);
            OP_LOAD: begin
               if (bfa_cmd_type'(req_cmd) == CMD_FREE_RUN && ridx < hint_ff) hint_ff <= ridx;
            end
            OP_TAKE1: begin
               used_ff <= used_ff + UW'(1);
               hint_ff <= rbase + CW'(first_free) + CW'(1);
            end
            OP_EXEC: begin
               unique case (cmd_ff)
                  CMD_FREE: begin
                     if (!(in_refs && ref_val != '0)) begin
                        if (in_tot && cur_bit) used_ff <= used_ff - UW'(1);
                        if (ixw < hint_ff) hint_ff <= ixw;
                     end
                  end
                  CMD_RESERVE: if (in_tot && !cur_bit) used_ff <= used_ff + UW'(1);
                  CMD_RELEASE: if (in_tot && cur_bit) used_ff <= used_ff - UW'(1);
                  default: ;
               endcase
            end
            OP_RFREE:    used_ff <= used_ff - UW'(pcnt);
            OP_RUN_DONE: used_ff <= used_ff + UW'(len_ff);
            default: ;
         endcase
      end
   end

   // working registers and result
   always_ff @(posedge clock) begin
      unique case (ctl.op)
         OP_LOAD: begin
            cmd_ff    <= bfa_cmd_type'(req_cmd);
            idx_ff    <= req_frame_index;
            len_ff    <= req_run_length;
            aln_ff    <= aln_eff;
            status_ff <= STS_OK;
            frame_ff  <= '0;
            refs_ff   <= '0;
            unique case (bfa_cmd_type'(req_cmd))
               CMD_ALLOC: begin
                  pos_ff <= hint_ff;
                  lim_ff <= tot;
               end
               CMD_ALLOC_RUN: begin
                  base_ff <= aln_eff;
                  pos_ff  <= aln_eff;
                  lim_ff  <= aln_eff + CW'(req_run_length);
               end
               CMD_FREE_RUN: begin
                  pos_ff <= ridx;
                  lim_ff <= (rlim < tot) ? rlim : tot;
               end
               default: pos_ff <= ridx;
            endcase
         end
         OP_WRAP: begin
            pos_ff <= '0;
            lim_ff <= (hint_ff < tot) ? hint_ff : tot;
         end
         OP_NEXT, OP_MARK, OP_RFREE: pos_ff <= row_end;
         OP_TAKE1: frame_ff  <= 16'(rbase + CW'(first_free));
         OP_FAIL:  status_ff <= STS_NO_FRAME;
         OP_ZLEN:  status_ff <= STS_ZERO_LEN;
         OP_EXEC: begin
            if (cmd_ff == CMD_ADDREF && in_refs) begin
               if (ref_val == 8'hFF) begin
                  status_ff <= STS_SATURATED;
                  refs_ff   <= 8'hFF;
               end else begin
                  refs_ff <= ref_val + 8'd1;
               end
            end else if (cmd_ff == CMD_QUERY && in_refs) begin
               refs_ff <= ref_val;
            end
         end
         OP_BLOCK: begin
            blk_ff  <= rbase + CW'(first_used);
            base_ff <= base_ff + aln_ff;
         end
         OP_STEP: base_ff <= base_ff + aln_ff;
         OP_REBASE: begin
            pos_ff <= base_ff;
            lim_ff <= base_ff + CW'(len_ff);
         end
         OP_MARK_START: pos_ff   <= base_ff;
         OP_RUN_DONE:   frame_ff <= base_ff[15:0];
         default: ;
      endcase
      if (ctl.push) begin
         rsp_status       <= status_ff;
         rsp_result_frame <= frame_ff;
         rsp_ref_count    <= refs_ff;
         rsp_used_total   <= used_ff[16:0];
      end
   end

endmodule

`default_nettype wire

>>> src/bfa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bfa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [2:0]           req_cmd,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output bfa_pkg::bfa_ctl_type ctl,
   input  bfa_pkg::bfa_sts_type sts
);
   import bfa_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_WAIT,
      S_ALLOC,
      S_EXEC,
      S_RCHK,
      S_RSCAN,
      S_RSTEP,
      S_RMARK,
      S_FSCAN,
      S_RESP
   } state_type;

   state_type state_ff, state_in, ret_ff, ret_in;
   logic      phase_ff, phase_in, rsp_valid_ff, rsp_valid_in;

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      phase_in = phase_ff;
      ctl.op   = OP_NONE;
      ctl.push = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            ctl.op = OP_CLEAR;
            if (sts.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               ctl.op   = OP_LOAD;
               phase_in = 1'b0;
               state_in = S_WAIT;
               unique case (bfa_cmd_type'(req_cmd))
                  CMD_ALLOC:     ret_in = S_ALLOC;
                  CMD_FREE_RUN:  ret_in = S_FSCAN;
                  CMD_ALLOC_RUN: state_in = S_RCHK;
                  default:       ret_in = S_EXEC;
               endcase
            end
         end
         S_WAIT: state_in = ret_ff;
         S_ALLOC: begin
            priority if (sts.empty) begin
               if (!phase_ff) begin
                  ctl.op   = OP_WRAP;
                  phase_in = 1'b1;
                  state_in = S_WAIT;
               end else begin
                  ctl.op   = OP_FAIL;
                  state_in = S_RESP;
               end
            end else if (sts.hit_free) begin
               ctl.op   = OP_TAKE1;
               state_in = S_RESP;
            end else begin
               ctl.op   = OP_NEXT;
               state_in = S_WAIT;
            end
         end
         S_EXEC: begin
            ctl.op   = OP_EXEC;
            state_in = S_RESP;
         end
         S_RCHK: begin
            priority if (sts.len_zero) begin
               ctl.op   = OP_ZLEN;
               state_in = S_RESP;
            end else if (sts.over) begin
               ctl.op   = OP_FAIL;
               state_in = S_RESP;
            end else begin
               state_in = S_WAIT;
               ret_in   = S_RSCAN;
            end
         end
         S_RSCAN: begin
            priority if (sts.empty) begin
               ctl.op   = OP_MARK_START;
               state_in = S_WAIT;
               ret_in   = S_RMARK;
            end else if (sts.hit_used) begin
               ctl.op   = OP_BLOCK;
               state_in = S_RSTEP;
            end else begin
               ctl.op   = OP_NEXT;
               state_in = S_WAIT;
            end
         end
         S_RSTEP: begin
            if (sts.base_le_blk) begin
               ctl.op = OP_STEP;
            end else begin
               ctl.op   = OP_REBASE;
               state_in = S_RCHK;
            end
         end
         S_RMARK: begin
            if (sts.empty) begin
               ctl.op   = OP_RUN_DONE;
               state_in = S_RESP;
            end else begin
               ctl.op   = OP_MARK;
               state_in = S_WAIT;
            end
         end
         S_FSCAN: begin
            if (sts.empty) begin
               state_in = S_RESP;
            end else begin
               ctl.op   = OP_RFREE;
               state_in = S_WAIT;
            end
         end
         S_RESP: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               ctl.push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (ctl.push) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         ret_ff       <= S_IDLE;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

>>> src/bfa_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module bfa_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [15:0] rsp_result_frame,
   input logic [7:0]  rsp_ref_count
);
   import bfa_pkg::*;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_frame))
      else $error("stalled result dropped or changed");

   a_fail_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STS_NO_FRAME || rsp_status == STS_ZERO_LEN)
      |-> rsp_result_frame == 16'd0)
      else $error("failed allocation reports a frame");

   a_sat_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STS_SATURATED |-> rsp_ref_count == 8'hFF)
      else $error("saturated refcount below maximum");

endmodule

bind bitmap_frame_allocator_top bfa_checker u_bfa_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_status       (rsp_ch.status),
   .rsp_result_frame (rsp_ch.result_frame),
   .rsp_ref_count    (rsp_ch.ref_count)
);

`default_nettype wire
